@@ rtl/kst_pkg.sv @@
`default_nettype none
package kst_pkg;
    typedef enum logic [2:0] {
        REQ_UPSERT = 3'd0,
        REQ_GET    = 3'd1,
        REQ_NEWEST = 3'd2,
        REQ_LIST_EP  = 3'd3,
        REQ_LIST_DEV = 3'd4
    } t_req;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_INSERT = 2'd2;
    localparam logic [1:0] ACT_EVICT  = 2'd3;

    localparam logic [1:0] KIND_BOOL = 2'd0;
    localparam logic [1:0] KIND_U64  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_WRITE,
        S_EMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [63:0] device;
        logic [7:0]  endpoint;
        logic [63:0] key;
        logic [1:0]  kind;
        logic [63:0] value;
        logic [63:0] time_ms;
    } t_entry;
endpackage
`default_nettype wire

@@ rtl/kst_mem.sv @@
`default_nettype none
// Entry store: one write port, one registered read port.
module kst_mem
    import kst_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);
    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/keyed_state_table_oldest_evict_unit.sv @@
`default_nettype none
// Channel   Direction  Handshake          Ports
// request   in         start / busy       i_req_type .. i_list_limit
// result    out        o_valid (strobe)   o_status .. o_last_item
//
// Each well-formed request scans the stored entries in order, one memory read a cycle.
// A list request then rereads each result from memory before it sends it out, and a
// malformed request is answered from the check state without a scan. Reset clears
// the control state and the entry count; the memory itself is not cleared, since no
// entry is read above the count. Results cannot be stalled.
module keyed_state_table_oldest_evict_unit
    import kst_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [63:0] i_device_id,
    input  wire logic [7:0]  i_endpoint_num,
    input  wire logic [63:0] i_key_code,
    input  wire logic [1:0]  i_value_kind,
    input  wire logic [63:0] i_data_value,
    input  wire logic [63:0] i_time_ms,
    input  wire logic [6:0]  i_list_limit,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [1:0]       o_action,
    output logic [63:0]      o_out_device,
    output logic [7:0]       o_out_endpoint,
    output logic [63:0]      o_out_key,
    output logic [1:0]       o_out_kind,
    output logic [63:0]      o_out_value,
    output logic [63:0]      o_out_time,
    output logic [6:0]       o_fill_count,
    output logic [0:0]       o_last_item
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [63:0] KEY_MASK =
        (KEY_BITS >= 64) ? {64{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);

    t_state r_state, n_state;
    logic [2:0]  r_req;
    t_entry      r_in;
    logic [6:0]  r_limit;
    logic [CW-1:0] r_count, n_count;
    // Scan pointer runs one ahead of the data returning from memory.
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_didx, n_didx;
    logic          r_dval, n_dval;
    logic          r_found, n_found;
    logic [AW-1:0] r_best, n_best;
    logic [63:0]   r_best_t, n_best_t;
    // Matching indices found by a list scan, kept in a small queue of registers.
    logic [AW-1:0] r_hits [TABLE_DEPTH];
    logic [CW-1:0] r_nhit, n_nhit;
    logic [CW-1:0] r_emit, n_emit;
    logic          r_emit_rd, n_emit_rd;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata, rd;

    logic [1:0]  n_status, n_action;
    logic        n_valid, n_last, n_with_entry;
    logic [6:0]  n_fill;

    kst_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    logic match_dev, match_ep, match_key, list_hit, scan_end, full_limit;
    always_comb begin
        match_dev = (rd.device == r_in.device);
        match_ep  = (rd.endpoint == r_in.endpoint);
        match_key = (rd.key == r_in.key);
        list_hit  = match_dev && (match_ep || (r_req == REQ_LIST_DEV));
        full_limit = (7'(r_nhit) >= r_limit);
        scan_end  = (r_ptr >= r_count);
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ptr = r_ptr;
        n_didx = r_ptr;
        n_dval = 1'b0;
        n_found = r_found;
        n_best = r_best;
        n_best_t = r_best_t;
        n_nhit = r_nhit;
        n_emit = r_emit;
        n_emit_rd = 1'b0;
        mem_we = 1'b0;
        mem_waddr = r_best;
        mem_wdata = r_in;
        mem_raddr = r_ptr[AW-1:0];
        n_valid = 1'b0;
        n_status = ST_OK;
        n_action = ACT_NONE;
        n_fill = '0;
        n_last = 1'b1;
        n_with_entry = 1'b0;
        busy = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_ptr = '0;
                n_found = 1'b0;
                n_nhit = '0;
                n_emit = '0;
                priority if (r_req > 3'(REQ_LIST_DEV)
                        || ((r_req == REQ_UPSERT)
                            && (r_in.device == '0 || r_in.key == '0))
                        || ((r_req == REQ_GET || r_req == REQ_NEWEST) && r_in.key == '0)
                        || ((r_req == REQ_LIST_EP || r_req == REQ_LIST_DEV)
                            && r_limit == '0)) begin
                    n_valid = 1'b1;
                    n_status = ST_INVALID;
                    n_state = S_IDLE;
                end else begin
                    mem_raddr = '0;
                    n_ptr = CW'(1);
                    n_didx = '0;
                    n_dval = (r_count != '0);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Look at the word read in the previous cycle.
                if (r_dval) begin
                    unique case (r_req)
                        REQ_UPSERT: begin
                            if (match_dev && match_ep && match_key && !r_found) begin
                                n_found = 1'b1;
                                n_best = r_didx[AW-1:0];
                            end else if (!r_found && (r_didx == '0
                                    || rd.time_ms < r_best_t)) begin
                                n_best = r_didx[AW-1:0];
                                n_best_t = rd.time_ms;
                            end
                        end
                        REQ_GET: begin
                            if (match_dev && match_ep && match_key && !r_found) begin
                                n_found = 1'b1;
                                n_best = r_didx[AW-1:0];
                            end
                        end
                        REQ_NEWEST: begin
                            if (match_dev && match_key
                                    && (!r_found || rd.time_ms > r_best_t)) begin
                                n_found = 1'b1;
                                n_best = r_didx[AW-1:0];
                                n_best_t = rd.time_ms;
                            end
                        end
                        default: begin
                            if (list_hit && !full_limit) begin
                                n_nhit = r_nhit + CW'(1);
                            end
                        end
                    endcase
                end
                if (r_dval && !scan_end) begin
                    mem_raddr = r_ptr[AW-1:0];
                    n_didx = r_ptr;
                    n_dval = 1'b1;
                    n_ptr = r_ptr + CW'(1);
                end else if (!r_dval) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                unique case (r_req)
                    REQ_UPSERT: begin
                        n_valid = 1'b1;
                        if (r_found) begin
                            mem_we = 1'b1;
                            n_action = ACT_UPDATE;
                            n_fill = 7'(r_count);
                        end else if (r_count < CW'(TABLE_DEPTH)) begin
                            mem_we = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                            n_action = ACT_INSERT;
                            n_fill = 7'(r_count + CW'(1));
                        end else begin
                            mem_we = 1'b1;
                            n_action = ACT_EVICT;
                            n_fill = 7'(r_count);
                        end
                        n_state = S_IDLE;
                    end
                    REQ_GET, REQ_NEWEST: begin
                        if (r_found) begin
                            mem_raddr = r_best;
                            n_state = S_DONE;
                        end else begin
                            n_valid = 1'b1;
                            n_status = ST_NOT_FOUND;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        if (r_nhit == '0) begin
                            n_valid = 1'b1;
                            n_status = ST_NOT_FOUND;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                endcase
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_with_entry = 1'b1;
                n_state = S_IDLE;
            end
            S_EMIT: begin
                // Read a hit's entry from memory, then pass it to the output registers.
                if (r_emit_rd) begin
                    n_valid = 1'b1;
                    n_with_entry = 1'b1;
                    n_fill = 7'(r_emit + CW'(1));
                    n_last = (r_emit + CW'(1) == r_nhit);
                    n_emit = r_emit + CW'(1);
                    if (n_last) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    mem_raddr = r_hits[r_emit[AW-1:0]];
                    n_emit_rd = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
            r_dval <= 1'b0;
            r_emit_rd <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            o_valid <= n_valid;
            r_dval <= n_dval;
            r_emit_rd <= n_emit_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_didx <= n_didx;
        r_found <= n_found;
        r_best <= n_best;
        r_best_t <= n_best_t;
        r_nhit <= n_nhit;
        r_emit <= n_emit;
        if (r_state == S_SCAN && r_dval && r_req >= 3'(REQ_LIST_EP)
                && list_hit && !full_limit) begin
            r_hits[r_nhit[AW-1:0]] <= r_didx[AW-1:0];
        end
        if (r_state == S_IDLE && start) begin
            r_req <= i_req_type;
            r_limit <= i_list_limit;
            r_in.device <= i_device_id;
            r_in.endpoint <= i_endpoint_num;
            r_in.key <= i_key_code & KEY_MASK;
            r_in.kind <= i_value_kind;
            r_in.time_ms <= i_time_ms;
            if (i_value_kind == KIND_BOOL) begin
                r_in.value <= {63'd0, (i_data_value != '0)};
            end else if (i_value_kind == KIND_U64) begin
                r_in.value <= i_data_value;
            end else begin
                r_in.value <= {32'd0, i_data_value[31:0]};
            end
        end
        o_status <= n_status;
        o_action <= n_action;
        o_fill_count <= n_fill;
        o_last_item <= n_last;
        o_out_device <= n_with_entry ? rd.device : '0;
        o_out_endpoint <= n_with_entry ? rd.endpoint : '0;
        o_out_key <= n_with_entry ? rd.key : '0;
        o_out_kind <= n_with_entry ? rd.kind : '0;
        o_out_value <= n_with_entry ? rd.value : '0;
        o_out_time <= n_with_entry ? rd.time_ms : '0;
    end
endmodule
`default_nettype wire

@@ bench/keyed_state_table_checker.sv @@
`default_nettype none
// Predicts what the state table sends back for every accepted request word and
// compares each result word against the oldest prediction still waiting.
module keyed_state_table_checker
    import kst_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [63:0] i_device_id,
    input  wire logic [7:0]  i_endpoint_num,
    input  wire logic [63:0] i_key_code,
    input  wire logic [1:0]  i_value_kind,
    input  wire logic [63:0] i_data_value,
    input  wire logic [63:0] i_time_ms,
    input  wire logic [6:0]  i_list_limit,
    input  wire logic        o_valid,
    input  wire logic [1:0]  o_status,
    input  wire logic [1:0]  o_action,
    input  wire logic [63:0] o_out_device,
    input  wire logic [7:0]  o_out_endpoint,
    input  wire logic [63:0] o_out_key,
    input  wire logic [1:0]  o_out_kind,
    input  wire logic [63:0] o_out_value,
    input  wire logic [63:0] o_out_time,
    input  wire logic [6:0]  o_fill_count,
    input  wire logic [0:0]  o_last_item,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;

    typedef struct {
        logic [1:0]  status;
        logic [1:0]  action;
        logic [63:0] device;
        logic [7:0]  endpoint;
        logic [63:0] key;
        logic [1:0]  kind;
        logic [63:0] value;
        logic [63:0] stamp;
        logic [6:0]  fill;
        logic        last;
    } t_reply;

    t_entry  table_q[DEPTH];
    int      used;
    t_reply  replies_due[$];

    function automatic t_reply blank_reply(logic [1:0] st, logic [1:0] act,
                                           logic [6:0] fill, logic last);
        t_reply r;
        r = '{default: '0};
        r.status = st;
        r.action = act;
        r.fill = fill;
        r.last = last;
        return r;
    endfunction

    function automatic t_reply entry_reply(int idx, logic [6:0] fill, logic last);
        t_reply r;
        r = blank_reply(ST_OK, ACT_NONE, fill, last);
        r.device = table_q[idx].device;
        r.endpoint = table_q[idx].endpoint;
        r.key = table_q[idx].key;
        r.kind = table_q[idx].kind;
        r.value = table_q[idx].value;
        r.stamp = table_q[idx].time_ms;
        return r;
    endfunction

    task automatic apply_request();
        t_entry e;
        int     hit;
        int     hits[$];
        e.device = i_device_id;
        e.endpoint = i_endpoint_num;
        e.key = i_key_code;
        e.kind = i_value_kind;
        e.time_ms = i_time_ms;
        if (i_value_kind == KIND_BOOL) begin
            e.value = (i_data_value != 0) ? 64'd1 : 64'd0;
        end else if (i_value_kind != KIND_U64) begin
            e.value = {32'd0, i_data_value[31:0]};
        end else begin
            e.value = i_data_value;
        end
        hit = -1;
        case (i_req_type)
            REQ_UPSERT: begin
                if (e.device == 0 || e.key == 0) begin
                    replies_due.push_back(blank_reply(ST_INVALID, ACT_NONE, 7'd0, 1'b1));
                end else begin
                    for (int i = 0; i < used; i++) begin
                        if (hit < 0 && table_q[i].device == e.device &&
                            table_q[i].endpoint == e.endpoint && table_q[i].key == e.key) begin
                            hit = i;
                        end
                    end
                    if (hit >= 0) begin
                        table_q[hit] = e;
                        replies_due.push_back(blank_reply(ST_OK, ACT_UPDATE, 7'(used), 1'b1));
                    end else if (used < DEPTH) begin
                        table_q[used] = e;
                        used++;
                        replies_due.push_back(blank_reply(ST_OK, ACT_INSERT, 7'(used), 1'b1));
                    end else begin
                        hit = 0;
                        for (int i = 1; i < used; i++) begin
                            if (table_q[i].time_ms < table_q[hit].time_ms) hit = i;
                        end
                        table_q[hit] = e;
                        replies_due.push_back(blank_reply(ST_OK, ACT_EVICT, 7'(used), 1'b1));
                    end
                end
            end
            REQ_GET, REQ_NEWEST: begin
                if (e.key == 0) begin
                    replies_due.push_back(blank_reply(ST_INVALID, ACT_NONE, 7'd0, 1'b1));
                end else begin
                    for (int i = 0; i < used; i++) begin
                        if (table_q[i].device == e.device && table_q[i].key == e.key) begin
                            if (i_req_type == REQ_GET) begin
                                if (hit < 0 && table_q[i].endpoint == e.endpoint) hit = i;
                            end else if (hit < 0 ||
                                         table_q[i].time_ms > table_q[hit].time_ms) begin
                                hit = i;
                            end
                        end
                    end
                    if (hit < 0) begin
                        replies_due.push_back(blank_reply(ST_NOT_FOUND, ACT_NONE, 7'd0, 1'b1));
                    end else begin
                        replies_due.push_back(entry_reply(hit, 7'd0, 1'b1));
                    end
                end
            end
            REQ_LIST_EP, REQ_LIST_DEV: begin
                if (i_list_limit == 0) begin
                    replies_due.push_back(blank_reply(ST_INVALID, ACT_NONE, 7'd0, 1'b1));
                end else begin
                    for (int i = 0; i < used && hits.size() < i_list_limit; i++) begin
                        if (table_q[i].device == e.device &&
                            (i_req_type == REQ_LIST_DEV || table_q[i].endpoint == e.endpoint)) begin
                            hits.push_back(i);
                        end
                    end
                    if (hits.size() == 0) begin
                        replies_due.push_back(blank_reply(ST_NOT_FOUND, ACT_NONE, 7'd0, 1'b1));
                    end
                    foreach (hits[k]) begin
                        replies_due.push_back(entry_reply(hits[k], 7'(k + 1),
                                                          k == hits.size() - 1));
                    end
                end
            end
            default: replies_due.push_back(blank_reply(ST_INVALID, ACT_NONE, 7'd0, 1'b1));
        endcase
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: mismatch in %s: expected %h, actual %h", $realtime, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            used = 0;
            replies_due.delete();
        end else begin
            if (start && !busy) apply_request();
            if (o_valid) begin
                o_checked++;
                if (replies_due.size() == 0) begin
                    $display("%0t: result word with no prediction waiting", $realtime);
                    o_fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", 64'(want.status), 64'(o_status));
                    check_field("action", 64'(want.action), 64'(o_action));
                    check_field("device", want.device, o_out_device);
                    check_field("endpoint", 64'(want.endpoint), 64'(o_out_endpoint));
                    check_field("key", want.key, o_out_key);
                    check_field("kind", 64'(want.kind), 64'(o_out_kind));
                    check_field("value", want.value, o_out_value);
                    check_field("time", want.stamp, o_out_time);
                    check_field("fill_count", 64'(want.fill), 64'(o_fill_count));
                    check_field("last_item", 64'(want.last), 64'(o_last_item));
                end
            end
        end
        o_pending = replies_due.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
        used = 0;
    end
endmodule
`default_nettype wire

@@ bench/keyed_state_table_oldest_evict_unit_tb.sv @@
`default_nettype none
// Top of the bench for the keyed state table. It drives request words, one
// per accepted start, with random gaps between them, and leaves all prediction
// and comparison to the checker that sits beside the block.
module keyed_state_table_oldest_evict_unit_tb
    import kst_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Request codes the block does not know; each must give a lone invalid result.
    localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
    localparam int RANDOM_WORDS = 137;
    // A request scans at most 32 entries and may send up to 32 results, and the
    // driver may pause between requests, so STALL_LIMIT catches only a real hang.
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_req_type = '0;
    logic [63:0] i_device_id = '0;
    logic [7:0]  i_endpoint_num = '0;
    logic [63:0] i_key_code = '0;
    logic [1:0]  i_value_kind = '0;
    logic [63:0] i_data_value = '0;
    logic [63:0] i_time_ms = '0;
    logic [6:0]  i_list_limit = '0;
    logic        o_valid;
    logic [1:0]  o_status, o_action, o_out_kind;
    logic [63:0] o_out_device, o_out_key, o_out_value, o_out_time;
    logic [7:0]  o_out_endpoint;
    logic [6:0]  o_fill_count;
    logic [0:0]  o_last_item;
    int          fail_count, pending, checked;
    int          words_sent = 0;
    int          idle_cycles = 0;

    // Small pools of devices, endpoints and keys, so that updates, lists and
    // evictions actually happen; entry 0 of each pool is all ones, the rest are random.
    logic [63:0] dev_pool[4];
    logic [7:0]  ep_pool[3];
    logic [63:0] key_pool[4];

    always #6 i_clk = ~i_clk;

    keyed_state_table_oldest_evict_unit u_top (.*);

    keyed_state_table_checker u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_checked(checked)
    );

    // The watchdog only counts cycles in which neither a request nor a result moves.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [63:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    // Waits the drawn gap, presents the word and holds it until the block is not busy.
    // With no gap, start simply stays high and the fields change under it.
    task automatic send_request(logic [2:0] req, logic [63:0] dev, logic [7:0] ep,
                                logic [63:0] key, logic [1:0] kind, logic [63:0] val,
                                logic [63:0] stamp, logic [6:0] limit);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= req;
        i_device_id <= dev;
        i_endpoint_num <= ep;
        i_key_code <= key;
        i_value_kind <= kind;
        i_data_value <= val;
        i_time_ms <= stamp;
        i_list_limit <= limit;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    initial begin
        logic [2:0]  req;
        logic [63:0] dev, key, stamp;
        int          pick;
        foreach (dev_pool[i]) dev_pool[i] = wide_random() | 64'd1;
        foreach (ep_pool[i]) ep_pool[i] = 8'($urandom);
        foreach (key_pool[i]) key_pool[i] = wide_random() | 64'd1;
        dev_pool[0] = '1;
        ep_pool[0] = 8'hFF;
        key_pool[0] = '1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty-table lookups, errors, inserts, an update, lookups with ties and lists.
        send_request(REQ_GET, dev_pool[0], 8'h00, key_pool[0], 2'd0, '0, '0, 7'd1);
        send_request(REQ_LIST_DEV, dev_pool[0], 8'h00, '0, 2'd0, '0, '0, 7'd64);
        send_request(REQ_UPSERT, '0, 8'h00, key_pool[0], 2'd3, '1, '1, 7'd0);
        send_request(REQ_UPSERT, dev_pool[0], 8'hFF, '0, 2'd3, '1, '1, 7'd0);
        send_request(REQ_UPSERT, dev_pool[0], 8'hFF, key_pool[0], KIND_BOOL, 64'h8000_0000_0000_0000,
                     64'd10, 7'd0);
        send_request(REQ_UPSERT, dev_pool[0], 8'h00, key_pool[0], 2'd1, '1, 64'd10, 7'd0);
        send_request(REQ_UPSERT, dev_pool[0], 8'h01, key_pool[0], 2'd2, 64'h1234_5678_9ABC_DEF0,
                     64'd10, 7'd0);
        send_request(REQ_UPSERT, dev_pool[0], 8'hFF, key_pool[0], KIND_U64, '1, '1, 7'd0);
        send_request(REQ_UPSERT, dev_pool[1], 8'h00, key_pool[1], KIND_BOOL, '0, '0, 7'd0);
        send_request(REQ_GET, dev_pool[0], 8'hFF, key_pool[0], 2'd0, '0, '0, 7'd0);
        send_request(REQ_GET, '0, 8'hFF, key_pool[0], 2'd0, '0, '0, 7'd0);
        send_request(REQ_GET, dev_pool[0], 8'hFF, '0, 2'd0, '0, '0, 7'd0);
        send_request(REQ_GET, dev_pool[0], 8'h02, key_pool[0], 2'd0, '0, '0, 7'd0);
        send_request(REQ_NEWEST, dev_pool[0], 8'h00, key_pool[0], 2'd0, '0, '0, 7'd0);
        send_request(REQ_NEWEST, dev_pool[1], 8'h00, key_pool[1], 2'd0, '0, '0, 7'd0);
        send_request(REQ_LIST_EP, dev_pool[0], 8'hFF, '0, 2'd0, '0, '0, 7'd64);
        send_request(REQ_LIST_DEV, dev_pool[0], 8'h00, '0, 2'd0, '0, '0, 7'd2);
        send_request(REQ_LIST_DEV, dev_pool[0], 8'h00, '0, 2'd0, '0, '0, 7'd127);
        send_request(REQ_LIST_DEV, dev_pool[0], 8'h00, '0, 2'd0, '0, '0, 7'd0);
        send_request(REQ_LIST_EP, '0, 8'h00, '0, 2'd0, '0, '0, 7'd5);
        for (int r = REQ_UNKNOWN_LO; r <= REQ_UNKNOWN_HI; r++) begin
            send_request(3'(r), dev_pool[0], 8'hFF, key_pool[0], 2'd3, '1, '1, 7'd127);
        end

        // Random part: mostly upserts from the pools, which fill the table and
        // then force evictions; the remainder are lookups, lists and stray words.
        // Timestamps are often small so that oldest and newest ties occur.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) req = REQ_UPSERT;
            else if (pick < 62) req = REQ_GET;
            else if (pick < 74) req = REQ_NEWEST;
            else if (pick < 84) req = REQ_LIST_EP;
            else if (pick < 94) req = REQ_LIST_DEV;
            else req = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
            dev = $urandom_range(0, 19) == 0 ? ($urandom_range(0, 1) ? '0 : wide_random())
                                             : dev_pool[$urandom_range(0, 3)];
            key = $urandom_range(0, 19) == 0 ? '0 : key_pool[$urandom_range(0, 3)];
            if ($urandom_range(0, 15) == 0) key = wide_random();
            stamp = $urandom_range(0, 2) == 0 ? wide_random() : 64'($urandom_range(0, 7));
            send_request(req, dev,
                         $urandom_range(0, 9) == 0 ? 8'($urandom) : ep_pool[$urandom_range(0, 2)],
                         key, 2'($urandom), wide_random(), stamp,
                         $urandom_range(0, 9) == 0 ? 7'($urandom) : 7'($urandom_range(0, 40)));
        end
        start <= 1'b0;
        // Let the checker book the last word before its backlog is looked at.
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d request words and checked %0d result words.", words_sent, checked);
        $display("Covered upsert insert, update and eviction, lookups, lists and bad requests.");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/kst_pkg.sv
rtl/kst_mem.sv
rtl/keyed_state_table_oldest_evict_unit.sv
bench/keyed_state_table_checker.sv
bench/keyed_state_table_oldest_evict_unit_tb.sv
